### sv/clamped_pid_step_assert.svh
// ----------------------------------------------------------------------------
// clamped_pid_step_assert.svh - assertion macros
// Shorthand for the clocked implication checks used in the PID step block.
// ----------------------------------------------------------------------------
`ifndef CLAMPED_PID_STEP_ASSERT_SVH
`define CLAMPED_PID_STEP_ASSERT_SVH

// same-cycle implication, off during reset
`define CPS_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define CPS_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/cps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_pkg - clamped PID step package
// Widths, reset values, register indexes and the microcode table.
// ----------------------------------------------------------------------------
package cps_pkg;

  // field widths
  localparam int POS_W   = 12;
  localparam int E_W     = POS_W + 1;
  localparam int DIFF_W  = E_W + 1;
  localparam int GAIN_W  = 16;
  localparam int PER_W   = 10;
  localparam int INT_W   = 24;
  localparam int ISUM_W  = INT_W + 1;
  localparam int DRV_W   = 8;
  localparam int DER_W   = 16;

  // datapath widths
  localparam int MA_W    = 33;
  localparam int MB_W    = 17;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int ACC_W   = 43;
  localparam int K1000   = 1000;

  // shared restoring divider
  localparam int DIVQ_W    = 24;
  localparam int DQS_W     = DIVQ_W + 1;
  localparam int DIV_CNT_W = $clog2(DIVQ_W + 1);

  // drive = trunc(total / 256000) = sign * ((|total| >> 11) / 125)
  // x / 125 = (x * 33555) >> 22 for every x up to DRV_SAT
  localparam int DRV_SHIFT    = 11;
  localparam int DRV_DIV      = 125;
  localparam int DRV_Q_W      = 9;
  localparam int DRVF_W       = DRV_Q_W + 1;
  localparam int DRV_SAT      = DRV_DIV << (DRV_Q_W - 1);
  localparam int DRV_SAT_W    = $clog2(DRV_SAT + 1);
  localparam int SH_W         = ACC_W - DRV_SHIFT;
  localparam int DRV_RECIP    = 33555;
  localparam int DRV_RECIP_SH = 22;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P        = 4'd0,
    REG_GAIN_I        = 4'd1,
    REG_GAIN_D        = 4'd2,
    REG_PERIOD_MS     = 4'd3,
    REG_INTEGRAL_HIGH = 4'd4,
    REG_INTEGRAL_LOW  = 4'd5,
    REG_DRIVE_HIGH    = 4'd6,
    REG_DRIVE_LOW     = 4'd7
  } cfg_reg_t;

  localparam logic [PER_W-1:0]        PERIOD_RST  = 10'd20;
  localparam logic signed [INT_W-1:0] INT_HI_RST  = 24'sd20000;
  localparam logic signed [INT_W-1:0] INT_LO_RST  = -24'sd20000;
  localparam logic signed [DRV_W-1:0] DRV_HI_RST  = 8'sd110;
  localparam logic signed [DRV_W-1:0] DRV_LO_RST  = -8'sd110;

  localparam int DER_MAX_DEF = 10;
  localparam int DER_MIN_DEF = -10;

  // microcode
  localparam int STEP_W = 4;

  typedef enum logic [2:0] {
    MA_E    = 3'd0,
    MA_DIFF = 3'd1,
    MA_GP   = 3'd2,
    MA_GD   = 3'd3,
    MA_ISUM = 3'd4,
    MA_PROD = 3'd5,
    MA_ZERO = 3'd6,
    MA_ASAT = 3'd7
  } ma_sel_t;

  typedef enum logic [2:0] {
    MB_PER   = 3'd0,
    MB_K1000 = 3'd1,
    MB_E     = 3'd2,
    MB_DER   = 3'd3,
    MB_GI    = 3'd4,
    MB_ZERO  = 3'd5,
    MB_RECIP = 3'd6
  } mb_sel_t;

  typedef enum logic [2:0] {
    ALU_NOP     = 3'd0,
    ALU_INT     = 3'd1,
    ALU_DIVD    = 3'd2,
    ALU_ACC_LD  = 3'd3,
    ALU_ACC_ADD = 3'd4,
    ALU_DER     = 3'd5,
    ALU_OUT     = 3'd7
  } alu_op_t;

  typedef enum logic [1:0] {
    SQ_NEXT    = 2'd0,
    SQ_BR_BUSY = 2'd1,
    SQ_END     = 2'd2
  } seq_op_t;

  typedef struct packed {
    ma_sel_t            a_sel;
    mb_sel_t            b_sel;
    alu_op_t            alu;
    seq_op_t            seq;
    logic [STEP_W-1:0]  target;
  } ucw_t;

  localparam logic [STEP_W-1:0] STEP_NONE   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_WAIT_D = 4'd6;

  // product of step n is in prod during step n+1
  function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
    ucw_t w;
    unique case (step)
      4'd0:  w = '{MA_E,    MB_PER,   ALU_NOP,     SQ_NEXT,    STEP_NONE};
      4'd1:  w = '{MA_DIFF, MB_K1000, ALU_INT,     SQ_NEXT,    STEP_NONE};
      4'd2:  w = '{MA_GP,   MB_E,     ALU_DIVD,    SQ_NEXT,    STEP_NONE};
      4'd3:  w = '{MA_PROD, MB_K1000, ALU_NOP,     SQ_NEXT,    STEP_NONE};
      4'd4:  w = '{MA_ISUM, MB_GI,    ALU_ACC_LD,  SQ_NEXT,    STEP_NONE};
      4'd5:  w = '{MA_ZERO, MB_ZERO,  ALU_ACC_ADD, SQ_NEXT,    STEP_NONE};
      4'd6:  w = '{MA_ZERO, MB_ZERO,  ALU_NOP,     SQ_BR_BUSY, STEP_WAIT_D};
      4'd7:  w = '{MA_ZERO, MB_ZERO,  ALU_DER,     SQ_NEXT,    STEP_NONE};
      4'd8:  w = '{MA_GD,   MB_DER,   ALU_NOP,     SQ_NEXT,    STEP_NONE};
      4'd9:  w = '{MA_PROD, MB_K1000, ALU_NOP,     SQ_NEXT,    STEP_NONE};
      4'd10: w = '{MA_ZERO, MB_ZERO,  ALU_ACC_ADD, SQ_NEXT,    STEP_NONE};
      // reciprocal product stays selected so prod holds while result stalls
      4'd11: w = '{MA_ASAT, MB_RECIP, ALU_NOP,     SQ_NEXT,    STEP_NONE};
      4'd12: w = '{MA_ASAT, MB_RECIP, ALU_OUT,     SQ_END,     STEP_NONE};
      default: w = '{MA_ZERO, MB_ZERO, ALU_NOP,    SQ_END,     STEP_NONE};
    endcase
    return w;
  endfunction

endpackage

### sv/cps_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_if - clamped PID step channels
// Valid/ready channels for ticks in, drive out and register writes.
// ----------------------------------------------------------------------------
interface cps_in_if;
  import cps_pkg::*;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] setpoint;
  logic             reversed;
  logic             restart;
  modport source (output valid, position, setpoint, reversed, restart, input ready);
  modport sink   (input valid, position, setpoint, reversed, restart, output ready);
endinterface

interface cps_out_if;
  import cps_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DRV_W-1:0] drive;
  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

interface cps_cfg_if;
  import cps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/clamped_pid_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clamped_pid_step - one tick of a clamped PID position controller
// Microcoded sequencer over a shared multiplier and a restoring divider.
// ----------------------------------------------------------------------------
// Each beat on tick is one control tick and gives exactly one beat on result.
// The block works one tick at a time: tick.ready is high only while the
// sequencer is idle. The result register is loaded and tick.ready returns
// at the same edge, when the final step finds the result register free.
// The 24-step derivative divide (error delta times 1000 over period_ms) on
// the restoring divider runs beside the 13-step microprogram, which waits in
// step 6 until the divider is done. The drive divide by 256000 is a shift
// and a reciprocal multiply on the shared multiplier. A finished drive sits
// in the result register while the next tick is accepted and worked; only
// the final microcode step waits for that register to empty. Register writes
// on cfg are taken in any cycle, but are meant to happen only while the
// block is idle.
// ----------------------------------------------------------------------------
module clamped_pid_step #(
  parameter int DER_MAX = cps_pkg::DER_MAX_DEF,
  parameter int DER_MIN = cps_pkg::DER_MIN_DEF
) (
  input  logic      clk,
  input  logic      rst,
  cps_cfg_if.sink   cfg,
  cps_in_if.sink    tick,
  cps_out_if.source result
);
  import cps_pkg::*;

  // configuration registers
  logic signed [GAIN_W-1:0] gain_p, gain_i, gain_d;
  logic [PER_W-1:0]         period_ms;
  logic signed [INT_W-1:0]  integral_high, integral_low;
  logic signed [DRV_W-1:0]  drive_high, drive_low;

  // controller state carried between ticks
  logic signed [INT_W-1:0]  isum;
  logic signed [E_W-1:0]    last_err;

  // captured tick
  logic [POS_W-1:0] pos_r, set_r;
  logic             rev_r, rst_r;

  // sequencer
  logic              run;
  logic [STEP_W-1:0] step;
  ucw_t              cw;
  logic              out_free, adv, do_alu, tick_acc;

  // datapath
  logic signed [MA_W-1:0]   ma;
  logic signed [MB_W-1:0]   mb;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [DER_W-1:0]  der;

  // shared divider: quotient bits shift in at the bottom of div_q
  logic [DIVQ_W-1:0]    div_q;
  logic [PER_W-1:0]     div_rem, div_den;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 div_neg, div_busy;
  logic [PER_W:0]       div_trial;

  // output register
  logic                    out_valid;
  logic signed [DRV_W-1:0] out_drive;

  // ---- combinational terms ----
  logic signed [E_W-1:0]    e_fwd, e, last_eff;
  logic signed [DIFF_W-1:0] diff;
  logic [PER_W-1:0]         per_eff;
  logic signed [INT_W-1:0]  base;
  logic signed [ISUM_W-1:0] isum_raw;
  logic signed [INT_W-1:0]  isum_next;
  logic signed [DQS_W-1:0]  dnum, dq;
  logic [DIVQ_W-1:0]        dmag;
  logic signed [DER_W-1:0]  der_next;
  logic [ACC_W-1:0]         amag;
  logic [SH_W-1:0]          ash;
  logic [DRV_SAT_W-1:0]     asat;
  logic [DRV_Q_W-1:0]       drv_q;
  logic signed [DRVF_W-1:0] drv_full;
  logic signed [DRV_W-1:0]  drv_next;

  assign cw       = ucode(step);
  assign out_free = !out_valid || result.ready;
  assign adv      = (cw.seq != SQ_END) || out_free;
  assign do_alu   = run && adv;
  assign tick_acc = tick.valid && tick.ready;
  assign div_busy = (div_cnt != '0);

  assign tick.ready   = !run;
  assign cfg.ready    = 1'b1;
  assign result.valid = out_valid;
  assign result.drive = out_drive;

  always_comb begin
    // error and delta; a restart tick sees zero history
    e_fwd    = $signed({1'b0, set_r}) - $signed({1'b0, pos_r});
    e        = rev_r ? -e_fwd : e_fwd;
    last_eff = rst_r ? '0 : last_err;
    diff     = DIFF_W'(e) - DIFF_W'(last_eff);
    per_eff  = (period_ms == '0) ? PER_W'(1) : period_ms;
    base     = rst_r ? '0 : isum;

    // integral: prod holds e * period here
    isum_raw = ISUM_W'(base) + ISUM_W'(prod);
    if (isum_raw > ISUM_W'(integral_high)) begin
      isum_next = integral_high;
    end else if (isum_raw < ISUM_W'(integral_low)) begin
      isum_next = integral_low;
    end else begin
      isum_next = INT_W'(isum_raw);
    end

    // derivative divide operands: prod holds delta * 1000
    dnum = DQS_W'(prod);
    dmag = DIVQ_W'(dnum[DQS_W-1] ? -dnum : dnum);

    // derivative result, truncated toward zero then clamped
    dq = div_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    if (dq > DQS_W'(DER_MAX)) begin
      der_next = DER_W'(DER_MAX);
    end else if (dq < DQS_W'(DER_MIN)) begin
      der_next = DER_W'(DER_MIN);
    end else begin
      der_next = DER_W'(dq);
    end

    // drive divide operand; anything at or past 256 clamps the same way
    amag = ACC_W'(acc[ACC_W-1] ? -acc : acc);
    ash  = amag[ACC_W-1:DRV_SHIFT];
    asat = (ash >= SH_W'(DRV_SAT)) ? DRV_SAT_W'(DRV_SAT) : ash[DRV_SAT_W-1:0];

    // quotient by 125 from the reciprocal product in prod
    drv_q    = prod[DRV_RECIP_SH +: DRV_Q_W];
    drv_full = acc[ACC_W-1] ? -$signed({1'b0, drv_q}) : $signed({1'b0, drv_q});
    if (drv_full > DRVF_W'(drive_high)) begin
      drv_next = drive_high;
    end else if (drv_full < DRVF_W'(drive_low)) begin
      drv_next = drive_low;
    end else begin
      drv_next = DRV_W'(drv_full);
    end

    div_trial = {div_rem, div_q[DIVQ_W-1]};
  end

  // multiplier operand select
  always_comb begin
    unique case (cw.a_sel)
      MA_E:    ma = MA_W'(e);
      MA_DIFF: ma = MA_W'(diff);
      MA_GP:   ma = MA_W'(gain_p);
      MA_GD:   ma = MA_W'(gain_d);
      MA_ISUM: ma = MA_W'(isum);
      MA_PROD: ma = MA_W'(prod);
      MA_ASAT: ma = MA_W'(asat);
      default: ma = '0;
    endcase
    unique case (cw.b_sel)
      MB_PER:   mb = MB_W'({1'b0, per_eff});
      MB_K1000: mb = MB_W'(K1000);
      MB_E:     mb = MB_W'(e);
      MB_DER:   mb = MB_W'(der);
      MB_GI:    mb = MB_W'(gain_i);
      MB_RECIP: mb = MB_W'(DRV_RECIP);
      default:  mb = '0;
    endcase
  end

  // ---- sequencer and handshake control ----
  always_ff @(posedge clk) begin
    if (rst) begin
      run       <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
      div_cnt   <= '0;
    end else begin
      if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (tick_acc) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        unique case (cw.seq)
          SQ_NEXT:    step <= step + 1'b1;
          SQ_BR_BUSY: step <= div_busy ? cw.target : step + 1'b1;
          SQ_END:     if (out_free) begin
            run <= 1'b0;
          end
          default:    step <= step;
        endcase
      end
      if (div_busy) begin
        div_cnt <= div_cnt - 1'b1;
      end
      if (do_alu) begin
        case (cw.alu)
          ALU_DIVD: div_cnt <= DIV_CNT_W'(DIVQ_W);
          ALU_OUT:  out_valid <= 1'b1;
          default:  ;
        endcase
      end
    end
  end

  // ---- configuration and carried state ----
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p        <= '0;
      gain_i        <= '0;
      gain_d        <= '0;
      period_ms     <= PERIOD_RST;
      integral_high <= INT_HI_RST;
      integral_low  <= INT_LO_RST;
      drive_high    <= DRV_HI_RST;
      drive_low     <= DRV_LO_RST;
      isum          <= '0;
      last_err      <= '0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_GAIN_P:        gain_p        <= cfg.data[GAIN_W-1:0];
          REG_GAIN_I:        gain_i        <= cfg.data[GAIN_W-1:0];
          REG_GAIN_D:        gain_d        <= cfg.data[GAIN_W-1:0];
          REG_PERIOD_MS:     period_ms     <= cfg.data[PER_W-1:0];
          REG_INTEGRAL_HIGH: integral_high <= cfg.data[INT_W-1:0];
          REG_INTEGRAL_LOW:  integral_low  <= cfg.data[INT_W-1:0];
          REG_DRIVE_HIGH:    drive_high    <= cfg.data[DRV_W-1:0];
          REG_DRIVE_LOW:     drive_low     <= cfg.data[DRV_W-1:0];
          default:           ;
        endcase
      end
      if (do_alu) begin
        case (cw.alu)
          ALU_INT:  isum     <= isum_next;
          ALU_DIVD: last_err <= e;
          default:  ;
        endcase
      end
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (tick_acc) begin
      pos_r <= tick.position;
      set_r <= tick.setpoint;
      rev_r <= tick.reversed;
      rst_r <= tick.restart;
    end
    if (div_busy) begin
      if (div_trial >= {1'b0, div_den}) begin
        div_rem <= PER_W'(div_trial - {1'b0, div_den});
        div_q   <= {div_q[DIVQ_W-2:0], 1'b1};
      end else begin
        div_rem <= div_trial[PER_W-1:0];
        div_q   <= {div_q[DIVQ_W-2:0], 1'b0};
      end
    end
    if (do_alu) begin
      case (cw.alu)
        ALU_ACC_LD:  acc <= ACC_W'(prod);
        ALU_ACC_ADD: acc <= acc + ACC_W'(prod);
        ALU_DER:     der <= der_next;
        ALU_DIVD: begin
          div_q   <= dmag;
          div_rem <= '0;
          div_den <= per_eff;
          div_neg <= dnum[DQS_W-1];
        end
        ALU_OUT:     out_drive <= drv_next;
        default:     ;
      endcase
    end
  end

  // ---- assertions ----
`include "clamped_pid_step_assert.svh"

  `CPS_AST_IMP(a_idle_div_quiet, tick.ready, div_cnt == '0, "divider busy while idle")
  `CPS_AST_NXT(a_accept_starts, tick_acc, !tick.ready && step == '0, "tick not started")
  `CPS_AST_NXT(a_end_loads_result, run && cw.seq == SQ_END && out_free,
               result.valid && tick.ready, "last step left no result")
  `CPS_AST_IMP(a_div_count_range, run, div_cnt <= DIV_CNT_W'(DIVQ_W), "divider count overrun")

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the clamped PID step block
// Drives control ticks and register writes through the valid/ready channels,
// predicts every drive beat with a cycle-free integer model of the controller
// and compares each result beat against the oldest prediction. Directed tests
// cover field and register extremes, the zero period, crossed clamp limits
// and writes to unused register indexes. Random phases then run tracking
// sequences under random configurations, most with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  import cps_pkg::*;

  // run shape
  localparam int RST_CYCLES  = 6;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_TICKS = 250;
  localparam int CYCLE_LIMIT = 2_000_000;
  // a little over the accept-to-result latency of the block
  localparam int TAIL_CYCLES = 40;

  localparam longint DRIVE_SCALE = 256000;
  localparam longint DER_CEIL    = DER_MAX_DEF;
  localparam longint DER_FLOOR   = DER_MIN_DEF;

  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = 4'd15;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] setpoint;
    logic             reversed;
    logic             restart;
  } tick_t;

  logic clk;
  logic rst;

  cps_cfg_if cfg_ch ();
  cps_in_if  tick_ch ();
  cps_out_if drive_ch ();

  clamped_pid_step u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .tick   (tick_ch),
    .result (drive_ch)
  );

  // --------------------------------------------------------------------------
  // Controller model: configuration copy and the two words of loop state
  // --------------------------------------------------------------------------
  logic signed [GAIN_W-1:0] kp      = '0;
  logic signed [GAIN_W-1:0] ki      = '0;
  logic signed [GAIN_W-1:0] kd      = '0;
  logic        [PER_W-1:0]  period  = PERIOD_RST;
  logic signed [INT_W-1:0]  isum_hi = INT_HI_RST;
  logic signed [INT_W-1:0]  isum_lo = INT_LO_RST;
  logic signed [DRV_W-1:0]  drv_hi  = DRV_HI_RST;
  logic signed [DRV_W-1:0]  drv_lo  = DRV_LO_RST;
  logic signed [INT_W-1:0]  isum     = '0;
  logic signed [E_W-1:0]    err_prev = '0;

  // drive beats still owed by the block, oldest first
  logic signed [DRV_W-1:0] drive_q[$];

  int  errors = 0;
  int  cycles = 0;
  // no idling on either side while set
  bit  calm   = 1'b1;

  // upper limit is tested first, so crossed limits behave as the block does
  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // one control tick: updates the loop state, returns the expected drive
  function automatic logic signed [DRV_W-1:0] predict_drive(input tick_t t);
    longint per, err, integ, der, total;
    // a zero period is taken as 1 ms
    per = (period == '0) ? 1 : longint'(period);
    if (t.restart) begin
      isum     = '0;
      err_prev = '0;
    end
    err = longint'(t.setpoint) - longint'(t.position);
    if (t.reversed) err = -err;
    integ = clip(longint'(isum) + err * per, longint'(isum_lo), longint'(isum_hi));
    der   = clip((err - longint'(err_prev)) * K1000 / per, DER_FLOOR, DER_CEIL);
    isum     = integ[INT_W-1:0];
    err_prev = err[E_W-1:0];
    total = longint'(kp) * err * K1000 + longint'(ki) * integ
          + longint'(kd) * der * K1000;
    return DRV_W'(clip(total / DRIVE_SCALE, longint'(drv_lo), longint'(drv_hi)));
  endfunction

  function automatic int field_width(input logic [CFG_IDX_W-1:0] idx);
    case (idx) inside
      REG_GAIN_P, REG_GAIN_I, REG_GAIN_D:   return GAIN_W;
      REG_PERIOD_MS:                        return PER_W;
      REG_INTEGRAL_HIGH, REG_INTEGRAL_LOW:  return INT_W;
      REG_DRIVE_HIGH, REG_DRIVE_LOW:        return DRV_W;
      default:                              return 0;
    endcase
  endfunction

  // value in the register's bits, random junk above them
  function automatic logic [CFG_DATA_W-1:0] pad_word(input int value, input int width);
    logic [CFG_DATA_W-1:0] w, m;
    w = CFG_DATA_W'($urandom);
    m = (CFG_DATA_W'(1) << width) - 1'b1;
    return (w & ~m) | (CFG_DATA_W'(value) & m);
  endfunction

  // idle stretch: mostly none or short, now and then long
  function automatic int idle_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return int'($urandom_range(1, 4));
    return int'($urandom_range(5, 90));
  endfunction

  // --------------------------------------------------------------------------
  // Clock, cycle count and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  task automatic finish_run(input bit ok);
    if (ok) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  endtask

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $error("timeout after %0d cycles, %0d drive beats outstanding",
           cycles, drive_q.size());
    finish_run(1'b0);
  end

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, and the drive check on every beat
  // --------------------------------------------------------------------------
  initial begin : drive_sink
    int run, stall;
    drive_ch.ready <= 1'b0;
    forever begin
      run = calm ? 1 : int'($urandom_range(1, 10));
      repeat (run) begin
        @(negedge clk);
        drive_ch.ready <= 1'b1;
      end
      stall = idle_len();
      repeat (stall) begin
        @(negedge clk);
        drive_ch.ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : drive_check
    logic signed [DRV_W-1:0] want;
    if (!rst && drive_ch.valid && drive_ch.ready) begin
      if (drive_q.size() == 0) begin
        $error("drive: expected no beat, got %0d", drive_ch.drive);
        errors++;
      end else begin
        want = drive_q.pop_front();
        if (drive_ch.drive !== want) begin
          $error("drive: expected %0d, got %0d", want, drive_ch.drive);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // One tick beat. valid is left high after the beat so that back-to-back
  // ticks never see valid dropped and raised in the same step; the next call
  // or settle() deals with it.
  task automatic send_tick(input logic [POS_W-1:0] pos, input logic [POS_W-1:0] set,
                           input logic rev, input logic restart);
    tick_t t;
    int    gap;
    t   = '{position: pos, setpoint: set, reversed: rev, restart: restart};
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_ch.valid    <= 1'b1;
    tick_ch.position <= t.position;
    tick_ch.setpoint <= t.setpoint;
    tick_ch.reversed <= t.reversed;
    tick_ch.restart  <= t.restart;
    do @(posedge clk); while (!tick_ch.ready);
    drive_q.push_back(predict_drive(t));
  endtask

  // stop sending and wait until every drive beat is in and the block idles
  task automatic settle();
    @(negedge clk);
    tick_ch.valid <= 1'b0;
    while (drive_q.size() != 0 || !tick_ch.ready) @(posedge clk);
  endtask

  // register write; only called once settle() has returned
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    logic [CFG_DATA_W-1:0] word;
    word = pad_word(value, field_width(idx));
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= word;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_GAIN_P:        kp      = word[GAIN_W-1:0];
      REG_GAIN_I:        ki      = word[GAIN_W-1:0];
      REG_GAIN_D:        kd      = word[GAIN_W-1:0];
      REG_PERIOD_MS:     period  = word[PER_W-1:0];
      REG_INTEGRAL_HIGH: isum_hi = word[INT_W-1:0];
      REG_INTEGRAL_LOW:  isum_lo = word[INT_W-1:0];
      REG_DRIVE_HIGH:    drv_hi  = word[DRV_W-1:0];
      REG_DRIVE_LOW:     drv_lo  = word[DRV_W-1:0];
      default: ;  // unused index: write has no effect
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------
  // Reset values: zero gains give zero drive, then the default integral clamp
  // (+/-20000) and the default period (20 ms) show through the I term.
  task automatic test_reset_values();
    send_tick(12'd100, 12'd900, 1'b0, 1'b0);
    send_tick(12'd4095, 12'd0, 1'b0, 1'b0);
    settle();
    write_reg(REG_GAIN_I, 256);
    send_tick(12'd0, 12'd4095, 1'b0, 1'b0);
    send_tick(12'd4095, 12'd0, 1'b0, 1'b0);
  endtask

  // field extremes, both error signs, reverse and restart
  task automatic test_field_extremes();
    settle();
    write_reg(REG_GAIN_P, 256);
    write_reg(REG_GAIN_I, 0);
    write_reg(REG_GAIN_D, 256);
    write_reg(REG_PERIOD_MS, 1000);
    send_tick(12'd0,    12'd4095, 1'b0, 1'b1);
    send_tick(12'd4095, 12'd0,    1'b0, 1'b0);
    send_tick(12'd4095, 12'd0,    1'b1, 1'b0);
    send_tick(12'd0,    12'd4095, 1'b1, 1'b0);
    send_tick(12'd0,    12'd0,    1'b0, 1'b1);
    send_tick(12'd4095, 12'd4095, 1'b1, 1'b0);
  endtask

  // every register at its extremes
  task automatic test_register_extremes();
    settle();
    write_reg(REG_GAIN_P, 32767);
    write_reg(REG_GAIN_I, -32768);
    write_reg(REG_GAIN_D, 32767);
    write_reg(REG_PERIOD_MS, 1023);
    write_reg(REG_INTEGRAL_HIGH, 8388607);
    write_reg(REG_INTEGRAL_LOW, -8388608);
    write_reg(REG_DRIVE_HIGH, 127);
    write_reg(REG_DRIVE_LOW, -128);
    send_tick(12'd0,    12'd4095, 1'b0, 1'b1);
    send_tick(12'd4095, 12'd0,    1'b0, 1'b0);
    send_tick(12'd2048, 12'd2047, 1'b0, 1'b0);
    settle();
    write_reg(REG_GAIN_P, -32768);
    write_reg(REG_GAIN_I, 32767);
    write_reg(REG_GAIN_D, -32768);
    write_reg(REG_PERIOD_MS, 1);
    send_tick(12'd0,    12'd4095, 1'b1, 1'b0);
    send_tick(12'd4095, 12'd1,    1'b0, 1'b0);
  endtask

  // zero period acts as one millisecond in both the integral and derivative
  task automatic test_zero_period();
    settle();
    write_reg(REG_GAIN_P, 16);
    write_reg(REG_GAIN_I, 1000);
    write_reg(REG_GAIN_D, 4000);
    write_reg(REG_PERIOD_MS, 0);
    send_tick(12'd1000, 12'd1003, 1'b0, 1'b1);
    send_tick(12'd1000, 12'd1002, 1'b0, 1'b0);
    send_tick(12'd1000, 12'd990,  1'b0, 1'b0);
  endtask

  // low limit above high limit on both clamps
  task automatic test_crossed_limits();
    settle();
    write_reg(REG_GAIN_P, 256);
    write_reg(REG_GAIN_I, 256);
    write_reg(REG_PERIOD_MS, 10);
    write_reg(REG_INTEGRAL_HIGH, -100);
    write_reg(REG_INTEGRAL_LOW, 100);
    write_reg(REG_DRIVE_HIGH, -5);
    write_reg(REG_DRIVE_LOW, 5);
    send_tick(12'd0,    12'd3000, 1'b0, 1'b1);
    send_tick(12'd3000, 12'd0,    1'b0, 1'b0);
    send_tick(12'd500,  12'd500,  1'b0, 1'b0);
    send_tick(12'd502,  12'd500,  1'b1, 1'b0);
  endtask

  // writes to indexes past the last register must change nothing
  task automatic test_unused_index();
    settle();
    write_reg(REG_FIRST_UNUSED, 5000);
    write_reg(REG_LAST_UNUSED, -1);
    send_tick(12'd100,  12'd4000, 1'b0, 1'b1);
    send_tick(12'd4000, 12'd100,  1'b0, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Random phases
  // --------------------------------------------------------------------------
  function automatic int draw_gain();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return -32768;
    if (r == 1) return 32767;
    if (r < 6) return int'($urandom_range(0, 2047)) - 1024;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic program_random_config();
    int unsigned r;
    int          lo, hi;
    write_reg(REG_GAIN_P, draw_gain());
    write_reg(REG_GAIN_I, draw_gain());
    write_reg(REG_GAIN_D, draw_gain());
    r = $urandom_range(0, 7);
    write_reg(REG_PERIOD_MS, (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 1023 :
                             int'($urandom_range(1, 1023)));
    // integral clamp: usually a sane window, sometimes full range or crossed
    r = $urandom_range(0, 7);
    if (r == 0) begin
      hi = 8388607;
      lo = -8388608;
    end else if (r == 1) begin
      hi = -int'($urandom_range(0, 50000));
      lo = int'($urandom_range(0, 50000));
    end else begin
      hi = int'($urandom_range(0, 200000));
      lo = -int'($urandom_range(0, 200000));
    end
    write_reg(REG_INTEGRAL_HIGH, hi);
    write_reg(REG_INTEGRAL_LOW, lo);
    r = $urandom_range(0, 7);
    if (r == 0) begin
      hi = 127;
      lo = -128;
    end else if (r == 1) begin
      hi = -int'($urandom_range(0, 128));
      lo = int'($urandom_range(0, 127));
    end else begin
      hi = int'($urandom_range(0, 127));
      lo = -int'($urandom_range(0, 128));
    end
    write_reg(REG_DRIVE_HIGH, hi);
    write_reg(REG_DRIVE_LOW, lo);
    if ($urandom_range(0, 3) == 0)
      write_reg(4'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)), int'($urandom));
  endtask

  // Plant follows the setpoint, so errors stay small and the integral and
  // derivative spend time off their clamps. A few ticks are pure noise.
  task automatic test_random_tracking();
    int unsigned r;
    int          aim, plant, delta;
    logic        rev;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      calm = (ph == 0) || ($urandom_range(0, 3) == 0);
      program_random_config();
      aim   = int'($urandom_range(0, 4095));
      plant = int'($urandom_range(0, 4095));
      rev   = 1'($urandom_range(0, 1));
      for (int n = 0; n < PHASE_TICKS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          send_tick(POS_W'($urandom), POS_W'($urandom), 1'($urandom), 1'($urandom));
        end else begin
          if (r < 10) rev = ~rev;
          delta = aim - plant;
          plant = plant + delta / 8 + int'($urandom_range(0, 6)) - 3;
          if (plant < 0) plant = 0;
          if (plant > 4095) plant = 4095;
          if (r < 13) begin
            aim = int'($urandom_range(0, 4095));
            send_tick(POS_W'(plant), POS_W'(aim), rev, 1'b1);
          end else begin
            send_tick(POS_W'(plant), POS_W'(aim), rev, 1'b0);
          end
        end
      end
    end
    calm = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run
    rst              <= 1'b1;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= '0;
    cfg_ch.data      <= '0;
    tick_ch.valid    <= 1'b0;
    tick_ch.position <= '0;
    tick_ch.setpoint <= '0;
    tick_ch.reversed <= 1'b0;
    tick_ch.restart  <= 1'b0;
    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // the first two directed tests run without idling, then the rest turn it on
    test_reset_values();
    test_field_extremes();
    calm = 1'b0;
    test_register_extremes();
    test_zero_period();
    test_crossed_limits();
    test_unused_index();
    test_random_tracking();
    settle();
    // a stray beat after the last one expected would show up here
    repeat (TAIL_CYCLES) @(posedge clk);
    finish_run(errors == 0);
  end

endmodule

### sim.f
+incdir+sv
sv/cps_pkg.sv
sv/cps_if.sv
sv/clamped_pid_step.sv
sim/tb.sv
